/* rtl/core/scst_pkg.sv */
// ----------------------------------------------------------------------------
// scst_pkg: shared types and constants for the connection state table
// Line count, operation codes, call states and stream word layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package scst_pkg;

  // number of switch lines held in the table
  localparam int unsigned LINES    = 8;
  localparam int unsigned LIDX_W   = $clog2(LINES);
  // request line number field width
  localparam int unsigned LINE_W   = 4;
  // query result mask covers lines 0..7 only
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned MATCH_W  = (LINES > MASK_W) ? LINES : MASK_W;
  localparam int unsigned LOWEST_W = 3;

  // operation codes
  localparam logic [2:0] OP_SET_PAIR   = 3'd0;
  localparam logic [2:0] OP_GET_PAIR   = 3'd1;
  localparam logic [2:0] OP_QUERY_LINE = 3'd2;
  localparam logic [2:0] OP_CLEAR_LINE = 3'd3;
  localparam logic [2:0] OP_CLEAR_ALL  = 3'd4;

  // call states
  typedef logic [1:0] call_state_t;
  localparam call_state_t ST_NONE = 2'd0;

  // one row of the table: state toward every other line
  typedef call_state_t [LINES-1:0] row_t;

  // request word, highest field first
  typedef struct packed {
    logic [2:0]        pad;
    call_state_t       state_value;
    logic [LINE_W-1:0] second_line;
    logic [LINE_W-1:0] first_line;
    logic [2:0]        op;
  } req_t;

  // result word, highest field first
  typedef struct packed {
    logic [MASK_W-1:0]   match_mask;
    logic [LOWEST_W-1:0] lowest_match;
    logic                found;
    logic                pair_connected;
    call_state_t         pair_state;
    logic                ok;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/symmetric_connection_state_table.sv */
// ----------------------------------------------------------------------------
// symmetric_connection_state_table
// Symmetric table of 2-bit call states for every pair of switch lines, with
// set, get, row query, line clear and full clear requests.
// ----------------------------------------------------------------------------
// Each request is captured in an input register, then read and updated
// against a flop table of LINES rows in the table stage and written to an
// output register, so one request is accepted every cycle while the output
// is not stalled by out_tready. The table is cleared to none at reset in the
// same cycle; no clearing pass is needed. Requests that touch the table see
// the effect of every earlier request.
`default_nettype none

module symmetric_connection_state_table (
  input  wire logic  clk,
  input  wire logic  rst_n,
  // request: op[2:0], first_line[6:3], second_line[10:7], state_value[12:11]
  input  wire logic  in_tvalid,
  output logic       in_tready,
  input  wire logic [$bits(scst_pkg::req_t)-1:0] in_tdata,
  // result: ok[0], pair_state[2:1], pair_connected[3], found[4],
  //         lowest_match[7:5], match_mask[15:8]
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output logic [$bits(scst_pkg::rsp_t)-1:0] out_tdata
);

  import scst_pkg::*;

  // input register
  logic  req_valid_r;
  req_t  req_r;
  // output register
  logic  out_valid_r;
  rsp_t  rsp_r;
  rsp_t  rsp_nxt;
  // table
  row_t  tbl_r [LINES];
  row_t  tbl_nxt [LINES];

  logic              fire;
  logic              a_ok;
  logic              b_ok;
  logic              pair_ok;
  logic [LIDX_W-1:0] a_idx;
  logic [LIDX_W-1:0] b_idx;
  row_t              a_row;
  logic [MATCH_W-1:0] match;
  logic [LOWEST_W-1:0] lowest;

  // stage advances when the output slot is free or being drained
  assign fire      = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r <= req_t'(in_tdata);
    end
  end

  // line and pair checks
  assign a_ok    = req_r.first_line  < LINE_W'(LINES);
  assign b_ok    = req_r.second_line < LINE_W'(LINES);
  assign pair_ok = a_ok && b_ok && (req_r.first_line != req_r.second_line);
  assign a_idx   = req_r.first_line[LIDX_W-1:0];
  assign b_idx   = req_r.second_line[LIDX_W-1:0];
  assign a_row   = tbl_r[a_idx];

  // row scan: other lines at or above the minimum state
  always_comb begin
    match = '0;
    for (int i = 0; i < LINES; i++) begin
      match[i] = (a_idx != LIDX_W'(i)) && (a_row[i] >= req_r.state_value);
    end
  end

  // lowest matching line, masked to the result width
  always_comb begin
    lowest = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (match[i]) begin
        lowest = LOWEST_W'(i);
      end
    end
  end

  // result
  always_comb begin
    rsp_nxt = '0;
    case (req_r.op)
      OP_SET_PAIR: begin
        rsp_nxt.ok = pair_ok;
      end
      OP_GET_PAIR: begin
        if (pair_ok) begin
          rsp_nxt.ok             = 1'b1;
          rsp_nxt.pair_state     = a_row[b_idx];
          rsp_nxt.pair_connected = a_row[b_idx] != ST_NONE;
        end
      end
      OP_QUERY_LINE: begin
        if (a_ok) begin
          rsp_nxt.ok           = 1'b1;
          rsp_nxt.found        = |match;
          rsp_nxt.lowest_match = lowest;
          rsp_nxt.match_mask   = match[MASK_W-1:0];
        end
      end
      OP_CLEAR_LINE: begin
        rsp_nxt.ok = a_ok;
      end
      OP_CLEAR_ALL: begin
        rsp_nxt.ok = 1'b1;
      end
      default: begin
        rsp_nxt = '0;
      end
    endcase
  end

  // table update
  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      tbl_nxt[r] = tbl_r[r];
    end
    if (fire) begin
      case (req_r.op)
        OP_SET_PAIR: begin
          if (pair_ok) begin
            tbl_nxt[a_idx][b_idx] = req_r.state_value;
            tbl_nxt[b_idx][a_idx] = req_r.state_value;
          end
        end
        OP_CLEAR_LINE: begin
          if (a_ok) begin
            for (int r = 0; r < LINES; r++) begin
              tbl_nxt[a_idx][r] = ST_NONE;
              tbl_nxt[r][a_idx] = ST_NONE;
            end
          end
        end
        OP_CLEAR_ALL: begin
          for (int r = 0; r < LINES; r++) begin
            tbl_nxt[r] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < LINES; r++) begin
        tbl_r[r] <= '0;
      end
    end else begin
      for (int r = 0; r < LINES; r++) begin
        tbl_r[r] <= tbl_nxt[r];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rsp_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic tbl_sym;
  logic tbl_zero;

  always_comb begin
    tbl_sym  = 1'b1;
    tbl_zero = 1'b1;
    for (int r = 0; r < LINES; r++) begin
      if (tbl_r[r] != '0) begin
        tbl_zero = 1'b0;
      end
      if (tbl_r[r][r] != ST_NONE) begin
        tbl_sym = 1'b0;
      end
      for (int c = 0; c < LINES; c++) begin
        if (tbl_r[r][c] != tbl_r[c][r]) begin
          tbl_sym = 1'b0;
        end
      end
    end
  end

  // table stays symmetric with an empty diagonal
  a_tbl_sym: assert property (@(posedge clk) disable iff (!rst_n) tbl_sym)
    else $error("connection table lost symmetry");

  // clear all empties the table
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req_r.op == OP_CLEAR_ALL |=> tbl_zero)
    else $error("clear all left entries");

  // a rejected request carries a neutral result
  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !rsp_r.ok |-> rsp_r == '0)
    else $error("rejected request with nonzero fields");

  // connected flag follows the pair state
  a_conn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> rsp_r.pair_connected == (rsp_r.pair_state != ST_NONE))
    else $error("connected flag mismatch");

  // a set pair is stored at the reverse entry as well
  a_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req_r.op == OP_SET_PAIR && pair_ok
    |=> tbl_r[$past(b_idx)][$past(a_idx)] == $past(req_r.state_value))
    else $error("set pair not stored");

endmodule

`default_nettype wire

/* verif/scst_result_checker.sv */
// ----------------------------------------------------------------------------
// scst_result_checker: result checker for the connection state table
// Watches the request and result streams, keeps its own copy of the call
// state table, works out the result of every accepted request and compares
// each accepted result field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
module scst_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import scst_pkg::*;

  localparam int MAX_REPORTS = 10;

  // shadow copy of the table, indexed [line][other line]
  call_state_t call_table [LINES][LINES];
  rsp_t        expected_results [$];
  int          fail_cnt;

  // apply one request to the shadow table and return its result
  function automatic rsp_t apply_table_request(input req_t r);
    rsp_t        res;
    int unsigned a;
    int unsigned b;
    logic        a_ok;
    logic        pair_ok;
    res     = '0;
    a       = r.first_line;
    b       = r.second_line;
    a_ok    = (a < LINES);
    pair_ok = a_ok && (b < LINES) && (a != b);
    case (r.op)
      OP_SET_PAIR: begin
        if (pair_ok) begin
          call_table[a][b] = r.state_value;
          call_table[b][a] = r.state_value;
          res.ok = 1'b1;
        end
      end
      OP_GET_PAIR: begin
        if (pair_ok) begin
          res.ok             = 1'b1;
          res.pair_state     = call_table[a][b];
          res.pair_connected = (call_table[a][b] != ST_NONE);
        end
      end
      OP_QUERY_LINE: begin
        if (a_ok) begin
          res.ok = 1'b1;
          for (int i = 0; i < LINES; i++) begin
            if (i != a && call_table[a][i] >= r.state_value) begin
              if (!res.found) begin
                res.found        = 1'b1;
                res.lowest_match = LOWEST_W'(i);
              end
              // only the low lines fit in the mask
              if (i < MASK_W) res.match_mask[i] = 1'b1;
            end
          end
        end
      end
      OP_CLEAR_LINE: begin
        if (a_ok) begin
          for (int i = 0; i < LINES; i++) begin
            call_table[a][i] = ST_NONE;
            call_table[i][a] = ST_NONE;
          end
          res.ok = 1'b1;
        end
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < LINES; i++)
          for (int j = 0; j < LINES; j++) call_table[i][j] = ST_NONE;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    rsp_t pred;
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++)
        for (int j = 0; j < LINES; j++) call_table[i][j] = ST_NONE;
      expected_results.delete();
      fail_cnt = 0;
    end else begin
      // results first, so a result arriving with no request ahead of it is caught
      if (out_tvalid && out_tready) begin
        got = rsp_t'(out_tdata);
        if (expected_results.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $display("%0t: unexpected result %h with nothing outstanding", $realtime, got);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got.ok != want.ok || got.pair_state != want.pair_state ||
              got.pair_connected != want.pair_connected || got.found != want.found ||
              got.lowest_match != want.lowest_match || got.match_mask != want.match_mask) begin
            if (fail_cnt < MAX_REPORTS) begin
              $display("%0t: result mismatch (expected/actual): ok %b/%b state %0d/%0d",
                       $realtime, want.ok, got.ok, want.pair_state, got.pair_state);
              $display("  conn %b/%b found %b/%b lowest %0d/%0d mask %h/%h",
                       want.pair_connected, got.pair_connected, want.found, got.found,
                       want.lowest_match, got.lowest_match, want.match_mask, got.match_mask);
            end
            fail_cnt++;
          end
        end
      end
      // accepted request: predict its result
      if (in_tvalid && in_tready) begin
        pred = apply_table_request(req_t'(in_tdata));
        expected_results.insert(expected_results.size(), pred);
      end
    end
    mismatches <= fail_cnt;
    pending    <= expected_results.size();
  end

endmodule

/* verif/symmetric_connection_state_table_tb.sv */
// ----------------------------------------------------------------------------
// symmetric_connection_state_table_tb: testbench for the connection state table
// Drives directed and random set, get, query, clear and unknown requests
// through the request stream under several idle and stall mixes, and takes
// the verdict from the result checker that sits beside the block.
// ----------------------------------------------------------------------------
module symmetric_connection_state_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scst_pkg::*;

  localparam int RANDOM_PER_PHASE = 335;
  localparam int QUIET_LIMIT      = 5000;
  localparam int DRAIN_CYCLES     = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int   mismatches;
  int   pending;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  int   quiet_cycles;
  logic in_acc;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  symmetric_connection_state_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  scst_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // request handshake as seen at the last rising edge
  always @(posedge clk) in_acc <= in_tvalid && in_tready;

  // receiver back-pressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_stall_pct);

  // watchdog: cycles with no handshake on either stream
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic req_t make_req(input logic [2:0] op, input int a, input int b,
                                    input int sv);
    req_t r;
    r             = '0;
    r.op          = op;
    r.first_line  = LINE_W'(a);
    r.second_line = LINE_W'(b);
    r.state_value = call_state_t'(sv);
    return r;
  endfunction

  // mostly valid lines, now and then a line past the table, up to 15
  function automatic int pick_line();
    if ($urandom_range(99) < 85) return $urandom_range(LINES - 1);
    return $urandom_range(15, LINES);
  endfunction

  // random request, weighted so the table fills up before it gets cleared
  function automatic req_t random_req();
    int          roll;
    logic [2:0]  op;
    int          a;
    int          b;
    roll = $urandom_range(99);
    if (roll < 40)      op = OP_SET_PAIR;
    else if (roll < 60) op = OP_GET_PAIR;
    else if (roll < 80) op = OP_QUERY_LINE;
    else if (roll < 90) op = OP_CLEAR_LINE;
    else if (roll < 92) op = OP_CLEAR_ALL;
    else                op = 3'($urandom_range(7, 5));
    a = pick_line();
    b = ($urandom_range(99) < 6) ? a : pick_line();
    return make_req(op, a, b, $urandom_range(3));
  endfunction

  // present one request and hold it until accepted; returns at a falling edge
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(negedge clk); while (!in_acc);
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, invalid lines and pairs, every op
    send_req(make_req(OP_QUERY_LINE, 0, 0, 0));          // minimum none matches all
    send_req(make_req(OP_QUERY_LINE, 0, 0, 1));          // empty table, nothing found
    send_req(make_req(OP_SET_PAIR, 0, LINES - 1, 3));
    send_req(make_req(OP_GET_PAIR, LINES - 1, 0, 0));    // reverse direction
    send_req(make_req(OP_SET_PAIR, 3, 3, 2));            // equal lines
    send_req(make_req(OP_SET_PAIR, LINES, 1, 1));        // line out of range
    send_req(make_req(OP_GET_PAIR, 15, 15, 3));
    send_req(make_req(OP_GET_PAIR, 1, 15, 3));
    send_req(make_req(OP_QUERY_LINE, 15, 0, 0));
    send_req(make_req(OP_CLEAR_LINE, 9, 0, 0));
    send_req(make_req(OP_SET_PAIR, LINES - 1, 1, 1));
    send_req(make_req(OP_SET_PAIR, LINES - 1, 4, 2));
    send_req(make_req(OP_QUERY_LINE, LINES - 1, 15, 3));
    send_req(make_req(OP_QUERY_LINE, LINES - 1, 0, 2));
    send_req(make_req(OP_QUERY_LINE, LINES - 1, 0, 1));
    send_req(make_req(OP_CLEAR_LINE, LINES - 1, 0, 0));
    send_req(make_req(OP_GET_PAIR, 0, LINES - 1, 0));
    send_req(make_req(OP_SET_PAIR, 2, 5, 2));
    send_req(make_req(OP_SET_PAIR, 6, 5, 3));
    send_req(make_req(OP_SET_PAIR, 6, 5, 0));            // disconnect
    send_req(make_req(OP_GET_PAIR, 5, 6, 0));
    send_req(make_req(OP_CLEAR_ALL, 15, 15, 3));
    send_req(make_req(OP_GET_PAIR, 2, 5, 0));
    send_req(make_req(3'd5, 1, 2, 3));                   // unknown ops
    send_req(make_req(3'd6, 15, 0, 1));
    send_req(make_req(3'd7, 2, 1, 2));
    drain_results();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 87; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 87; end
        default: begin in_idle_pct = 23; out_stall_pct = 23; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_req(random_req());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* symmetric_connection_state_table.f */
rtl/core/scst_pkg.sv
rtl/core/symmetric_connection_state_table.sv
verif/scst_result_checker.sv
verif/symmetric_connection_state_table_tb.sv
